### src/mrps_pkg.sv
// ----------------------------------------------------------------------------
// mrps_pkg
// Shared types and constants of the most reliable path search core.
// ----------------------------------------------------------------------------
package mrps_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VW = 6;
    localparam int RW = FRAC_BITS + 1;
    localparam int CW = 7;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]    kind;
        logic [VW-1:0] from_vertex;
        logic [VW-1:0] to_vertex;
        logic [RW-1:0] edge_reliability;
    } t_in_word;

    typedef struct packed {
        logic          found;
        logic [RW-1:0] path_reliability;
        logic [VW-1:0] path_vertex;
        logic          last;
    } t_out_word;

endpackage

### src/mrps_ram.sv
// ----------------------------------------------------------------------------
// mrps_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module mrps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/most_reliable_path_search_core.sv
// ----------------------------------------------------------------------------
// most_reliable_path_search_core
// Dijkstra search for the most reliable path over a stored edge list.
// ----------------------------------------------------------------------------
// Add and clear words are taken while the core is idle. A query runs under a
// small sequencer: for each settled vertex, a scan of the best-value RAM finds
// the best open vertex, a pick step settles it, then the stored edges stream
// through the single shared multiplier and compare. The path words then walk the
// back links and wait out any output stall. Best values, back links and edges
// sit in RAMs; a per-vertex written flag makes best values read as zero at the
// start of each query, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module most_reliable_path_search_core
    import mrps_pkg::*;
#(
    parameter int MAX_VERT  = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [CW-1:0] i_cfg_wdata,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  t_in_word      i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output t_out_word     o_out_data
);

    localparam int AW  = $clog2(MAX_EDGES);
    localparam int FW  = AW + 1;
    localparam int XW  = $clog2(MAX_VERT);
    localparam int NW  = VW + 1;
    localparam int EW  = 2 * VW + RW;
    localparam logic [RW-1:0] ONE_FIX = RW'(1) << FRAC_BITS;
    localparam logic [MAX_VERT-1:0] VONE = MAX_VERT'(1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_PICK  = 7'b0000100,
        S_EDGE  = 7'b0001000,
        S_OUT   = 7'b0010000,
        S_WALK  = 7'b0100000,
        S_NF    = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_vcount;
    logic [FW-1:0]       r_fill;
    logic [MAX_VERT-1:0] r_done;
    logic [MAX_VERT-1:0] r_seen;
    logic [NW-1:0]       r_n;
    logic [VW-1:0]       r_src, r_dst;
    logic [NW-1:0]       r_v;
    logic [NW-1:0]       r_u;
    logic [RW-1:0]       r_ub;
    logic [FW-1:0]       r_e;
    logic                r_s1, r_s2;
    logic [XW-1:0]       r_h;
    logic [RW-1:0]       r_prod;
    logic                r_wen;
    logic [XW-1:0]       r_wh;
    logic [RW-1:0]       r_wval;
    logic [VW-1:0]       r_pv;
    logic [NW-1:0]       r_cnt;
    logic                r_ovalid;
    logic                n_ovalid;
    t_out_word           r_odata;

    logic [EW-1:0]   w_rdata;
    logic            w_we;
    logic [EW-1:0]   w_wdata;
    logic [AW-1:0]   w_raddr;
    logic [VW-1:0]   w_tail, w_head;
    logic [RW-1:0]   w_rel;
    logic [2*RW-1:0] w_prod;
    logic [RW-1:0]   w_prodt;
    logic [NW-1:0]   w_nclip;
    logic            w_accept;
    logic            w_ofree;
    logic [RW-1:0]   w_rin;
    logic [XW-1:0]   w_hi, w_srci;
    logic            w_qacc;
    logic [RW-1:0]   w_best_rd;
    logic            w_bwe;
    logic [XW-1:0]   w_bwaddr, w_braddr;
    logic [RW-1:0]   w_bwdata;
    logic [VW-1:0]   w_prev_rd;
    logic [NW-1:0]   w_vp;
    logic [XW-1:0]   w_vpi;
    logic [RW-1:0]   w_cand;
    logic            w_scan_upd;
    logic            w_q1;
    logic [RW-1:0]   w_cur;
    logic            w_upd;
    logic            w_edge_end;
    logic            w_fin;
    logic            w_emit;

    assign w_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_ofree = !r_ovalid || !i_out_stall;
    assign w_qacc = w_accept && (i_in_data.kind == KIND_QUERY);
    assign w_srci = i_in_data.from_vertex[XW-1:0];

    assign w_rin = (i_in_data.edge_reliability > ONE_FIX) ? ONE_FIX
                                                           : i_in_data.edge_reliability;
    assign w_we = w_accept && (i_in_data.kind == KIND_ADD) && (r_fill < FW'(MAX_EDGES));
    assign w_wdata = {i_in_data.from_vertex, i_in_data.to_vertex, w_rin};
    assign w_raddr = r_e[AW-1:0];

    mrps_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edges (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_fill[AW-1:0]),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_tail  = w_rdata[EW-1 -: VW];
    assign w_head  = w_rdata[RW +: VW];
    assign w_rel   = w_rdata[RW-1:0];
    assign w_prod  = (2*RW)'(r_ub) * (2*RW)'(w_rel);
    assign w_prodt = RW'(w_prod >> FRAC_BITS);
    assign w_hi    = w_head[XW-1:0];

    assign w_vp       = r_v - NW'(1);
    assign w_vpi      = w_vp[XW-1:0];
    assign w_cand     = r_seen[w_vpi] ? w_best_rd : '0;
    assign w_scan_upd = (r_v != '0) && !r_done[w_vpi] && (w_cand > r_ub);

    assign w_q1 = r_s1 && ({1'b0, w_tail} == r_u) && ({1'b0, w_head} < r_n) && !r_done[w_hi];
    assign w_cur = (r_wen && r_wh == r_h) ? r_wval : (r_seen[r_h] ? w_best_rd : '0);
    assign w_upd = (r_state == S_EDGE) && r_s2 && (r_prod > w_cur);
    assign w_edge_end = (r_e == r_fill) && !r_s1 && !r_s2;

    assign w_bwe    = w_qacc || w_upd;
    assign w_bwaddr = w_qacc ? w_srci : r_h;
    assign w_bwdata = w_qacc ? ONE_FIX : r_prod;
    assign w_braddr = (r_state == S_SCAN) ? r_v[XW-1:0] : w_hi;

    mrps_ram #(.WIDTH(RW), .DEPTH(MAX_VERT)) u_best (
        .i_clk  (i_clk),
        .i_we   (w_bwe),
        .i_waddr(w_bwaddr),
        .i_wdata(w_bwdata),
        .i_raddr(w_braddr),
        .o_rdata(w_best_rd)
    );

    mrps_ram #(.WIDTH(VW), .DEPTH(MAX_VERT)) u_prev (
        .i_clk  (i_clk),
        .i_we   (w_upd),
        .i_waddr(r_h),
        .i_wdata(r_u[VW-1:0]),
        .i_raddr(r_pv[XW-1:0]),
        .o_rdata(w_prev_rd)
    );

    assign w_fin  = (r_pv == r_src) || (r_cnt + NW'(1) == r_n);
    assign w_emit = w_ofree && (r_state == S_OUT || r_state == S_NF);
    assign n_ovalid = w_emit || (r_ovalid && i_out_stall);

    always_comb begin
        if (r_vcount == '0) begin
            w_nclip = NW'(1);
        end else if (r_vcount > CW'(MAX_VERT)) begin
            w_nclip = NW'(MAX_VERT);
        end else begin
            w_nclip = NW'(r_vcount);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_qacc) begin
                    if ({1'b0, i_in_data.from_vertex} >= w_nclip ||
                        {1'b0, i_in_data.to_vertex} >= w_nclip) begin
                        n_state = S_NF;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: if (r_v == r_n) n_state = S_PICK;
            S_PICK: begin
                if (r_u >= r_n) n_state = S_NF;
                else if (r_u == {1'b0, r_dst}) n_state = S_OUT;
                else n_state = S_EDGE;
            end
            S_EDGE: if (w_edge_end) n_state = S_SCAN;
            S_OUT:  if (w_ofree) n_state = w_fin ? S_IDLE : S_WALK;
            S_WALK: n_state = S_OUT;
            S_NF:   if (w_ofree) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vcount <= CW'(64);
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) r_vcount <= i_cfg_wdata;
            if (w_accept) begin
                unique case (i_in_data.kind)
                    KIND_ADD:   if (w_we) r_fill <= r_fill + FW'(1);
                    KIND_CLEAR: r_fill <= '0;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_n   <= w_nclip;
                r_src <= i_in_data.from_vertex;
                r_dst <= i_in_data.to_vertex;
                r_v   <= '0;
                r_u   <= w_nclip;
                r_ub  <= '0;
                if (w_qacc) begin
                    r_done <= '0;
                    r_seen <= VONE << w_srci;
                end
            end
            S_SCAN: begin
                if (r_v != r_n) r_v <= r_v + NW'(1);
                if (w_scan_upd) begin
                    r_ub <= w_cand;
                    r_u  <= w_vp;
                end
            end
            S_PICK: begin
                if (r_u < r_n) r_done[r_u[XW-1:0]] <= 1'b1;
                r_e   <= '0;
                r_s1  <= 1'b0;
                r_s2  <= 1'b0;
                r_wen <= 1'b0;
                r_pv  <= r_dst;
                r_cnt <= '0;
            end
            S_EDGE: begin
                if (r_e != r_fill) r_e <= r_e + FW'(1);
                r_s1   <= (r_e != r_fill);
                r_s2   <= w_q1;
                r_h    <= w_hi;
                r_prod <= w_prodt;
                r_wen  <= w_upd;
                r_wh   <= r_h;
                r_wval <= r_prod;
                if (w_upd) r_seen[r_h] <= 1'b1;
                if (w_edge_end) begin
                    r_v  <= '0;
                    r_u  <= r_n;
                    r_ub <= '0;
                end
            end
            S_OUT: begin
                if (w_ofree) begin
                    r_odata.found            <= 1'b1;
                    r_odata.path_reliability <= r_ub;
                    r_odata.path_vertex      <= r_pv;
                    r_odata.last             <= w_fin;
                    r_cnt <= r_cnt + NW'(1);
                end
            end
            S_WALK: r_pv <= w_prev_rd;
            S_NF: begin
                if (w_ofree) begin
                    r_odata.found            <= 1'b0;
                    r_odata.path_reliability <= '0;
                    r_odata.path_vertex      <= '0;
                    r_odata.last             <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule
